// ===== src/uuidtp_pkg.sv =====
package uuidtp_pkg;

	localparam int unsigned POS_W = 6;
	localparam int unsigned RESULT_W = 163;
	localparam int unsigned TDATA_OUT_W = 168;

	localparam logic [POS_W-1:0] LEN_SHORT16 = 6'd4;
	localparam logic [POS_W-1:0] LEN_SHORT32 = 6'd8;
	localparam logic [POS_W-1:0] LEN_FULL    = 6'd36;
	localparam logic [POS_W-1:0] POS_SAT     = 6'd37;

	localparam logic [POS_W-1:0] HYPHEN_POS_A = 6'd8;
	localparam logic [POS_W-1:0] HYPHEN_POS_B = 6'd13;
	localparam logic [POS_W-1:0] HYPHEN_POS_C = 6'd18;
	localparam logic [POS_W-1:0] HYPHEN_POS_D = 6'd23;

	localparam logic [7:0] ASCII_HYPHEN = 8'h2d;
	localparam logic [7:0] ASCII_0      = 8'h30;
	localparam logic [7:0] ASCII_9      = 8'h39;
	localparam logic [7:0] ASCII_UC_A   = 8'h41;
	localparam logic [7:0] ASCII_UC_F   = 8'h46;
	localparam logic [7:0] ASCII_LC_A   = 8'h61;
	localparam logic [7:0] ASCII_LC_F   = 8'h66;

	localparam logic [31:0] BASE_TAIL_HIGH32 = 32'h0000_1000;
	localparam logic [63:0] BASE_TAIL_LOW64  = 64'h8000_0080_5f9b_34fb;

	typedef struct packed {
		logic       shift_en;
		logic       set_err;
		logic [3:0] nibble;
	} dec_t;

	typedef struct packed {
		logic        short16_valid;
		logic [31:0] short32;
		logic        short32_valid;
		logic [63:0] uuid_low;
		logic [63:0] uuid_high;
		logic        status;
	} res_t;

endpackage

// ===== src/uuidtp_char_decode.sv =====
module uuidtp_char_decode (
	input  logic [7:0]                char_code,
	input  logic [uuidtp_pkg::POS_W-1:0] pos,
	output uuidtp_pkg::dec_t          dec
);
	import uuidtp_pkg::*;

	logic is_digit;
	logic is_upper;
	logic is_lower;
	logic in_range;
	logic hyphen_pos;

	always_comb begin
		is_digit   = (char_code >= ASCII_0) && (char_code <= ASCII_9);
		is_upper   = (char_code >= ASCII_UC_A) && (char_code <= ASCII_UC_F);
		is_lower   = (char_code >= ASCII_LC_A) && (char_code <= ASCII_LC_F);
		in_range   = pos < LEN_FULL;
		hyphen_pos = (pos == HYPHEN_POS_A) || (pos == HYPHEN_POS_B) ||
			(pos == HYPHEN_POS_C) || (pos == HYPHEN_POS_D);

		// Letters A-F and a-f carry their value minus nine in the low nibble.
		dec.nibble = is_digit ? char_code[3:0] : char_code[3:0] + 4'd9;

		if (!in_range) begin
			dec.shift_en = 1'b0;
			dec.set_err  = 1'b0;
		end else if (hyphen_pos) begin
			dec.shift_en = 1'b0;
			dec.set_err  = char_code != ASCII_HYPHEN;
		end else begin
			dec.shift_en = is_digit || is_upper || is_lower;
			dec.set_err  = !(is_digit || is_upper || is_lower);
		end
	end

endmodule

// ===== src/uuidtp_assemble.sv =====
module uuidtp_assemble (
	input  logic [uuidtp_pkg::POS_W-1:0] length,
	input  logic                         err,
	input  logic [127:0]                 acc,
	output uuidtp_pkg::res_t             res
);
	import uuidtp_pkg::*;

	logic        short_form;
	logic        full_form;
	logic        bad;
	logic [63:0] hi;
	logic [63:0] lo;
	logic        tail_match;

	always_comb begin
		short_form = (length == LEN_SHORT16) || (length == LEN_SHORT32);
		full_form  = length == LEN_FULL;
		bad        = err || !(short_form || full_form);

		if (short_form) begin
			hi = {acc[31:0], BASE_TAIL_HIGH32};
			lo = BASE_TAIL_LOW64;
		end else begin
			hi = acc[127:64];
			lo = acc[63:0];
		end

		tail_match = (hi[31:0] == BASE_TAIL_HIGH32) && (lo == BASE_TAIL_LOW64);

		res.status        = bad;
		res.uuid_high     = bad ? 64'd0 : hi;
		res.uuid_low      = bad ? 64'd0 : lo;
		res.short32_valid = !bad && tail_match;
		res.short32       = (!bad && tail_match) ? hi[63:32] : 32'd0;
		res.short16_valid = !bad && tail_match && (hi[63:48] == 16'd0);
	end

endmodule

// ===== src/uuid_text_parser.sv =====
// Channel  Dir  Word                         Meaning
// s_*      in   tdata[7:0]=char_code, tlast   one text character, tlast on the final one
// m_*      out  tdata: see port comment       one parse result per text
//
// A new word is accepted every cycle unless a final character waits behind a stalled result.
// A word is held in the input register; from there the decode updates the parse
// state and, on the final character, the result assembly writes the output register.
// A final character passes the input register and then the output register to its result.
// Reset clears the position, the error flag, the accumulator and both valids.
// A stalled result holds the pipe only when a final character waits behind it.
module uuid_text_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // [7:0] char_code
	input  logic         s_tlast,  // is_last
	output logic         m_tvalid,
	input  logic         m_tready,
	// [0] status, [64:1] uuid_high, [128:65] uuid_low, [129] short32_valid,
	// [161:130] short32, [162] short16_valid, [167:163] zero
	output logic [uuidtp_pkg::TDATA_OUT_W-1:0] m_tdata
);
	import uuidtp_pkg::*;

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             last_s1;

	logic [POS_W-1:0] pos_q;
	logic             err_q;
	logic [127:0]     acc_q;

	logic             out_valid_q;
	res_t             res_q;

	dec_t             dec;
	res_t             res;
	logic             advance;
	logic [POS_W-1:0] length;
	logic             err_next;
	logic [127:0]     acc_next;

	uuidtp_char_decode u_decode (
		.char_code (char_s1),
		.pos       (pos_q),
		.dec       (dec)
	);

	// A character that ends no text never waits for the output side.
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_comb begin
		length   = (pos_q >= POS_SAT) ? POS_SAT : pos_q + 6'd1;
		err_next = err_q || dec.set_err;
		acc_next = dec.shift_en ? {acc_q[123:0], dec.nibble} : acc_q;
	end

	uuidtp_assemble u_assemble (
		.length (length),
		.err    (err_next),
		.acc    (acc_next),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Parse state; the final character of a text returns it to reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			err_q <= 1'b0;
			acc_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				pos_q <= '0;
				err_q <= 1'b0;
				acc_q <= '0;
			end else begin
				pos_q <= length;
				err_q <= err_next;
				acc_q <= acc_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TDATA_OUT_W - RESULT_W){1'b0}}, res_q};

`ifndef SYNTH
	a_pos_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_SAT)
		else $error("position counter beyond saturation");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> pos_q == '0 && !err_q && acc_q == '0)
		else $error("parse state not cleared after final character");

	a_error_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.status |->
			res_q.uuid_high == 64'd0 && res_q.uuid_low == 64'd0 && !res_q.short32_valid)
		else $error("error result carries data");

	a_short16_implies_32: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.short16_valid |-> res_q.short32_valid)
		else $error("16-bit form valid without 32-bit form");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |-> !(advance && last_s1))
		else $error("pending result overwritten");
`endif

endmodule
